@@ rtl/alla_pkg.sv @@
// alla_pkg: shared types, constants and the sensor table for the lux linearizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package alla_pkg;

    // Table geometry (entries past the ninth repeat the last point)
    localparam int TABLE_POINTS = 9;
    localparam int TABLE_CAP    = 16;
    localparam int PT_W         = $clog2(TABLE_CAP);
    localparam logic [PT_W-1:0] PT_LAST = PT_W'(TABLE_POINTS - 1);

    // Field widths
    localparam int CODE_W  = 12;
    localparam int MV_W    = 12;
    localparam int LUX_W   = 18;
    localparam int CNT_W   = 7;
    localparam int VOLT_W  = 22;   // microvolts, at most 4095000
    localparam int SPAN_W  = 20;   // widest table segment in microvolts
    localparam int SUM_W   = 24;
    localparam int ACC_W   = 38;   // widest serial product / dividend
    localparam int MLT_W   = 18;   // serial multiplier register
    localparam int STEP_W  = 6;    // serial step counter

    // Serial step counts for each pass
    localparam logic [STEP_W-1:0] STEPS_MUL_V = STEP_W'(CODE_W);
    localparam logic [STEP_W-1:0] STEPS_DIV_V = STEP_W'(34);
    localparam logic [STEP_W-1:0] STEPS_MUL_I = STEP_W'(MLT_W);
    localparam logic [STEP_W-1:0] STEPS_DIV_I = STEP_W'(ACC_W);
    localparam logic [STEP_W-1:0] STEPS_DIV_A = STEP_W'(SUM_W);

    localparam logic [SPAN_W-1:0] ADC_FULL_SCALE = SPAN_W'(4095);
    localparam logic [CNT_W-1:0]  AVG_RESET      = CNT_W'(6);
    localparam logic [CNT_W-1:0]  AVG_MAX        = CNT_W'(64);

    // Channel payloads
    typedef struct packed {
        logic [CODE_W-1:0] adc_code;
        logic [MV_W-1:0]   supply_mv;
    } in_beat_t;

    typedef struct packed {
        logic [LUX_W-1:0] lux_now;
        logic             average_valid;
        logic [LUX_W-1:0] lux_average;
    } out_beat_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_V,
        ST_DIV_V,
        ST_SCAN,
        ST_MUL_I,
        ST_DIV_I,
        ST_ACC,
        ST_DIV_A,
        ST_DONE
    } state_t;

    // Breakpoint voltages in microvolts
    function automatic logic [VOLT_W-1:0] tbl_volt(input logic [PT_W-1:0] idx);
        logic [VOLT_W-1:0] v;
        case (idx)
            4'd0:    v = VOLT_W'(1150);
            4'd1:    v = VOLT_W'(3391);
            4'd2:    v = VOLT_W'(11498);
            4'd3:    v = VOLT_W'(41803);
            4'd4:    v = VOLT_W'(151990);
            4'd5:    v = VOLT_W'(533670);
            4'd6:    v = VOLT_W'(1368900);
            4'd7:    v = VOLT_W'(1906800);
            default: v = VOLT_W'(2300000);
        endcase
        return v;
    endfunction

    // Breakpoint illuminance in 1/256 lux (the 73.52 lux point dips on purpose)
    function automatic logic [LUX_W-1:0] tbl_lux(input logic [PT_W-1:0] idx);
        logic [LUX_W-1:0] l;
        case (idx)
            4'd0:    l = LUX_W'(259);
            4'd1:    l = LUX_W'(799);
            4'd2:    l = LUX_W'(2510);
            4'd3:    l = LUX_W'(7022);
            4'd4:    l = LUX_W'(17804);
            4'd5:    l = LUX_W'(59564);
            4'd6:    l = LUX_W'(165148);
            4'd7:    l = LUX_W'(18821);
            default: l = LUX_W'(256000);
        endcase
        return l;
    endfunction

endpackage

@@ rtl/adc_lux_linearize_average.sv @@
// ADC code to lux linearizer with windowed averaging, bit-serial datapath.
// Depends on alla_pkg (types, step counts, breakpoint table).
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one beat per sensor
//   sample: a 12-bit ADC code and the supply in mV. Output channel
//   (out_valid / out_stall / out_data) returns one beat per sample: its lux,
//   and every average_count samples the truncated window average.
//   cfg_we / cfg_data write average_count (0 acts as 1, above 64 as 64).
// Datapath:
//   One shared shift-add multiplier (1 bit per cycle) and one shared restoring
//   divider (1 quotient bit per cycle) do all the arithmetic. Per sample:
//   multiply code*supply, divide by 4095, scan the table, multiply and divide
//   again when the voltage lies between breakpoints, accumulate, divide the
//   window sum when a window closes, then load the output register. The next
//   beat is taken only once the sequencer is back in idle, so the block does
//   not take a new sample before it is through with the last one.
// Reset: sequencer idle, window sum and count cleared, average_count = 6,
//   output register empty.
// Stall: a finished beat holds in the output register while the block goes
//   idle and takes the next sample; a second result waits in the last state.

module adc_lux_linearize_average
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  alla_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output alla_pkg::out_beat_t out_data,
    input  logic                cfg_we,
    input  logic [alla_pkg::CNT_W-1:0] cfg_data
);
    import alla_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    avg_cnt_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    samples_reg, samples_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [MLT_W-1:0]    mult_reg, mult_next;
    logic [VOLT_W-1:0]   mcand_reg, mcand_next;
    logic [ACC_W-1:0]    num_reg, num_next;
    logic [SPAN_W-1:0]   rem_reg, rem_next;
    logic [SPAN_W-1:0]   divisor_reg, divisor_next;
    logic [VOLT_W-1:0]   volt_reg, volt_next;
    logic [PT_W-1:0]     pt_reg, pt_next;
    logic [LUX_W-1:0]    base_reg, base_next;
    logic                neg_reg, neg_next;
    logic [LUX_W-1:0]    lux_reg, lux_next;
    logic                avg_valid_reg, avg_valid_next;
    logic [LUX_W-1:0]    avg_reg, avg_next;
    logic                out_valid_reg;
    out_beat_t           out_data_reg;

    logic                in_fire;
    logic                last_step;
    logic                out_free;

    // Serial multiplier step: MSB first shift-add
    logic [ACC_W-1:0]    mul_sum;
    // Serial divider step: one restoring subtract
    logic [SPAN_W:0]     div_shift;
    logic [SPAN_W+1:0]   div_trial;
    logic                div_qbit;
    logic [ACC_W-1:0]    div_quot;
    logic [SPAN_W-1:0]   div_rem;

    // Table scan
    logic [VOLT_W-1:0]   tv_hi, tv_lo;
    logic [LUX_W-1:0]    tl_hi, tl_lo;
    logic                scan_le, scan_exact, scan_last;
    logic [LUX_W:0]      dy;
    logic [VOLT_W-1:0]   delta;
    logic [VOLT_W-1:0]   span;

    // Interpolation finish and window
    logic [LUX_W:0]      interp;
    logic [SUM_W-1:0]    sum_add;
    logic [CNT_W-1:0]    samples_inc;
    logic [CNT_W-1:0]    eff_cnt;
    logic                win_close;
    logic [MV_W+10-1:0]  mv1000;

    assign in_fire   = in_valid && !in_stall;
    assign last_step = (step_reg == STEP_W'(1));
    assign out_free  = !out_valid_reg || !out_stall;

    // Shared arithmetic
    assign mul_sum   = {acc_reg[ACC_W-2:0], 1'b0}
                     + (mult_reg[MLT_W-1] ? ACC_W'(mcand_reg) : '0);
    assign div_shift = {rem_reg, num_reg[ACC_W-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, divisor_reg};
    assign div_qbit  = !div_trial[SPAN_W+1];
    assign div_quot  = {num_reg[ACC_W-2:0], div_qbit};
    assign div_rem   = div_qbit ? div_trial[SPAN_W-1:0] : div_shift[SPAN_W-1:0];

    // Table lookups around the scan pointer
    assign tv_hi      = tbl_volt(pt_reg);
    assign tv_lo      = tbl_volt(pt_reg - PT_W'(1));
    assign tl_hi      = tbl_lux(pt_reg);
    assign tl_lo      = tbl_lux(pt_reg - PT_W'(1));
    assign scan_le    = (volt_reg <= tv_hi);
    assign scan_exact = (volt_reg == tv_hi) || (pt_reg == '0);
    assign scan_last  = (pt_reg == PT_LAST);
    assign dy         = {1'b0, tl_hi} - {1'b0, tl_lo};
    assign delta      = volt_reg - tv_lo;
    assign span       = tv_hi - tv_lo;

    // supply * 1000 = supply * (1024 - 16 - 8)
    assign mv1000 = ({in_data.supply_mv, 10'b0})
                  - ({6'b0, in_data.supply_mv, 4'b0})
                  - ({7'b0, in_data.supply_mv, 3'b0});

    // Signed finish of the interpolation, clamped at zero
    assign interp = neg_reg ? ({1'b0, base_reg} - {1'b0, div_quot[LUX_W-1:0]})
                            : ({1'b0, base_reg} + {1'b0, div_quot[LUX_W-1:0]});

    // Window bookkeeping
    assign sum_add     = sum_reg + SUM_W'(lux_reg);
    assign samples_inc = samples_reg + CNT_W'(1);
    assign eff_cnt     = (avg_cnt_reg == '0)    ? CNT_W'(1) :
                         (avg_cnt_reg > AVG_MAX) ? AVG_MAX  : avg_cnt_reg;
    assign win_close   = (samples_inc >= eff_cnt);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_MUL_V;
            ST_MUL_V: if (last_step) state_next = ST_DIV_V;
            ST_DIV_V: if (last_step) state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_le)
                    state_next = scan_exact ? ST_ACC : ST_MUL_I;
                else if (scan_last)
                    state_next = ST_ACC;
            end
            ST_MUL_I: if (last_step) state_next = ST_DIV_I;
            ST_DIV_I: if (last_step) state_next = ST_ACC;
            ST_ACC:   state_next = win_close ? ST_DIV_A : ST_DONE;
            ST_DIV_A: if (last_step) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath controls per state
    always_comb
    begin
        step_next      = step_reg - STEP_W'(1);
        acc_next       = acc_reg;
        mult_next      = mult_reg;
        mcand_next     = mcand_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        volt_next      = volt_reg;
        pt_next        = pt_reg;
        base_next      = base_reg;
        neg_next       = neg_reg;
        lux_next       = lux_reg;
        avg_valid_next = avg_valid_reg;
        avg_next       = avg_reg;
        sum_next       = sum_reg;
        samples_next   = samples_reg;
        in_stall       = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                step_next  = STEPS_MUL_V;
                acc_next   = '0;
                mult_next  = {in_data.adc_code, (MLT_W-CODE_W)'(0)};
                mcand_next = mv1000;
            end
            ST_MUL_V:
            begin
                acc_next  = mul_sum;
                mult_next = {mult_reg[MLT_W-2:0], 1'b0};
                if (last_step)
                begin
                    num_next     = {mul_sum[ACC_W-5:0], 4'b0};
                    rem_next     = '0;
                    divisor_next = ADC_FULL_SCALE;
                    step_next    = STEPS_DIV_V;
                end
            end
            ST_DIV_V:
            begin
                num_next = div_quot;
                rem_next = div_rem;
                if (last_step)
                begin
                    volt_next = div_quot[VOLT_W-1:0];
                    pt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_le && !scan_exact)
                begin
                    // start interpolation on segment below the pointer
                    acc_next     = '0;
                    mcand_next   = delta;
                    neg_next     = dy[LUX_W];
                    mult_next    = dy[LUX_W] ? MLT_W'(-dy) : dy[LUX_W-1:0];
                    base_next    = tl_lo;
                    divisor_next = span[SPAN_W-1:0];
                    step_next    = STEPS_MUL_I;
                end
                else if (scan_le || scan_last)
                begin
                    lux_next = tl_hi;
                end
                else
                begin
                    pt_next = pt_reg + PT_W'(1);
                end
            end
            ST_MUL_I:
            begin
                acc_next  = mul_sum;
                mult_next = {mult_reg[MLT_W-2:0], 1'b0};
                if (last_step)
                begin
                    num_next  = mul_sum;
                    rem_next  = '0;
                    step_next = STEPS_DIV_I;
                end
            end
            ST_DIV_I:
            begin
                num_next = div_quot;
                rem_next = div_rem;
                if (last_step)
                    lux_next = interp[LUX_W] && neg_reg ? '0 : interp[LUX_W-1:0];
            end
            ST_ACC:
            begin
                if (win_close)
                begin
                    num_next     = {sum_add, (ACC_W-SUM_W)'(0)};
                    rem_next     = '0;
                    divisor_next = SPAN_W'(samples_inc);
                    step_next    = STEPS_DIV_A;
                    sum_next     = '0;
                    samples_next = '0;
                end
                else
                begin
                    sum_next       = sum_add;
                    samples_next   = samples_inc;
                    avg_valid_next = 1'b0;
                    avg_next       = '0;
                end
            end
            ST_DIV_A:
            begin
                num_next = div_quot;
                rem_next = div_rem;
                if (last_step)
                begin
                    avg_valid_next = 1'b1;
                    avg_next       = div_quot[LUX_W-1:0];
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            avg_cnt_reg   <= AVG_RESET;
            sum_reg       <= '0;
            samples_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            samples_reg <= samples_next;
            if (cfg_we)
                avg_cnt_reg <= cfg_data;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        step_reg      <= step_next;
        acc_reg       <= acc_next;
        mult_reg      <= mult_next;
        mcand_reg     <= mcand_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        divisor_reg   <= divisor_next;
        volt_reg      <= volt_next;
        pt_reg        <= pt_next;
        base_reg      <= base_next;
        neg_reg       <= neg_next;
        lux_reg       <= lux_next;
        avg_valid_reg <= avg_valid_next;
        avg_reg       <= avg_next;
        if (state_reg == ST_DONE && out_free)
        begin
            out_data_reg.lux_now       <= lux_reg;
            out_data_reg.average_valid <= avg_valid_reg;
            out_data_reg.lux_average   <= avg_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/alla_chk.sv @@
// alla_chk: port-level checks for the lux linearizer, bound to the top level.
// Depends on alla_pkg and adc_lux_linearize_average.
`timescale 1ns / 1ps

module alla_chk
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input alla_pkg::out_beat_t out_data
);
    import alla_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // the block works one sample at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second beat taken while busy");

    // average field is zero unless a window closes
    a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.average_valid |-> out_data.lux_average == '0)
        else $error("average nonzero without valid flag");

    // lux stays inside the table's output range
    a_lux_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.lux_now >= LUX_W'(259)
                   && out_data.lux_now <= LUX_W'(256000)
                   && out_data.lux_average <= LUX_W'(256000))
        else $error("lux outside table range");

endmodule

bind adc_lux_linearize_average alla_chk u_alla_chk (.*);

@@ tb/tb.sv @@
// Testbench for adc_lux_linearize_average: drives sensor samples and checks lux and averages.
// Depends on alla_pkg and the adc_lux_linearize_average RTL; self-contained otherwise.
`timescale 1ns / 1ps

module tb;
    import alla_pkg::*;

    // Sensor curve, microvolts to 1/256 lux (the 73.52 lux point dips)
    localparam longint BP_UV [9] = '{1150, 3391, 11498, 41803, 151990,
                                     533670, 1368900, 1906800, 2300000};
    localparam longint BP_LUX [9] = '{259, 799, 2510, 7022, 17804,
                                      59564, 165148, 18821, 256000};
    localparam int BURST_CYCLES = 600;

    // Expected lux per sample and the averaging window it feeds
    class lux_scoreboard;
        out_beat_t        pending_lux [$];
        logic [CNT_W-1:0] window_len;
        logic [SUM_W-1:0] window_sum;
        logic [CNT_W-1:0] window_fill;
        int               errors;

        function new();
            window_len  = AVG_RESET;
            window_sum  = '0;
            window_fill = '0;
            errors      = 0;
        endfunction

        function void set_window(logic [CNT_W-1:0] n);
            window_len = n;
        endfunction

        function int pending();
            return pending_lux.size();
        endfunction

        // Piecewise linear lookup, quotient truncates toward zero
        function logic [LUX_W-1:0] lux_of_uv(longint uv);
            longint r;
            int     p;
            if (uv <= BP_UV[0])
                return LUX_W'(BP_LUX[0]);
            if (uv >= BP_UV[8])
                return LUX_W'(BP_LUX[8]);
            p = 1;
            while (p < 8 && uv > BP_UV[p])
                p++;
            if (uv == BP_UV[p])
                return LUX_W'(BP_LUX[p]);
            r = BP_LUX[p-1] + ((uv - BP_UV[p-1]) * (BP_LUX[p] - BP_LUX[p-1]))
                / (BP_UV[p] - BP_UV[p-1]);
            if (r < 0)
                r = 0;
            return LUX_W'(r);
        endfunction

        // Accepted input beat: predict its output beat
        function void note_sample(in_beat_t s);
            longint           uv;
            int               eff;
            logic [LUX_W-1:0] lux;
            out_beat_t        e;
            uv  = (longint'(s.adc_code) * longint'(s.supply_mv) * 1000) / 4095;
            lux = lux_of_uv(uv);
            eff = window_len;
            if (eff == 0)
                eff = 1;
            if (eff > 64)
                eff = 64;
            window_sum  = window_sum + SUM_W'(lux);
            window_fill = window_fill + 1'b1;
            e.lux_now       = lux;
            e.average_valid = 1'b0;
            e.lux_average   = '0;
            if (window_fill >= eff)
            begin
                e.average_valid = 1'b1;
                e.lux_average   = LUX_W'(window_sum / window_fill);
                window_sum      = '0;
                window_fill     = '0;
            end
            pending_lux.push_back(e);
        endfunction

        // Accepted output beat: compare with the oldest prediction
        function void check_beat(out_beat_t got);
            out_beat_t e;
            if (pending_lux.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                return;
            end
            e = pending_lux.pop_front();
            if (got.lux_now !== e.lux_now)
            begin
                errors++;
                $display("%0t: lux_now expected %0d actual %0d",
                         $time, e.lux_now, got.lux_now);
            end
            if (got.average_valid !== e.average_valid)
            begin
                errors++;
                $display("%0t: average_valid expected %0d actual %0d",
                         $time, e.average_valid, got.average_valid);
            end
            if (got.lux_average !== e.lux_average)
            begin
                errors++;
                $display("%0t: lux_average expected %0d actual %0d",
                         $time, e.lux_average, got.lux_average);
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    in_beat_t         in_data = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_beat_t        out_data;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;

    bit               quiet_run = 1'b0;
    bit               burst_req = 1'b0;
    int               burst_left = 0;
    lux_scoreboard    sb = new();

    adc_lux_linearize_average DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Receiver: random stalls, a long hold-off on request, none when quiet
    always @(negedge clk)
    begin
        if (burst_req)
        begin
            burst_left = BURST_CYCLES;
            burst_req  = 1'b0;
        end
        if (burst_left > 0)
        begin
            out_stall = 1'b1;
            burst_left--;
        end
        else if (quiet_run)
            out_stall = 1'b0;
        else
            out_stall = ($urandom_range(0, 99) < 26);
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_beat(out_data);
    end

    // Offer one sample, with random gaps ahead of it; returns once accepted
    task automatic offer_sample(input logic [CODE_W-1:0] code, input logic [MV_W-1:0] mv);
        while (!quiet_run && $urandom_range(0, 99) < 26)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid          = 1'b1;
        in_data.adc_code  = code;
        in_data.supply_mv = mv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_sample(in_data);
    endtask

    // Pick an input pair whose voltage lands on or just above a target
    task automatic offer_voltage(input longint target);
        longint            c;
        longint            v;
        longint            best;
        logic [CODE_W-1:0] code;
        logic [MV_W-1:0]   mv;
        best = 64'h7FFF_FFFF;
        code = '0;
        mv   = '0;
        for (longint m = 4095; m >= 1 && best != 0; m--)
        begin
            c = (target * 4095 + m * 1000 - 1) / (m * 1000);
            if (c <= 4095)
            begin
                v = (c * m * 1000) / 4095;
                if (v - target < best)
                begin
                    best = v - target;
                    code = CODE_W'(c);
                    mv   = MV_W'(m);
                end
            end
        end
        offer_sample(code, mv);
    endtask

    // Random samples, weighted toward low voltages so every segment is hit
    task automatic run_random(input int n);
        logic [CODE_W-1:0] code;
        logic [MV_W-1:0]   mv;
        for (int i = 0; i < n; i++)
        begin
            code = CODE_W'($urandom_range(0, 4095));
            if ($urandom_range(0, 99) < 60)
                code = code >> $urandom_range(0, 11);
            if ($urandom_range(0, 99) < 80)
                mv = MV_W'($urandom_range(0, 3600));
            else
                mv = MV_W'($urandom_range(0, 4095));
            offer_sample(code, mv);
        end
    endtask

    // Drop valid and wait for every predicted beat to come back
    task automatic drain;
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write, only with the block idle
    task automatic write_window(input logic [CNT_W-1:0] n);
        drain();
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = n;
        @(posedge clk);
        sb.set_window(n);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Timeout
    initial
    begin
        #8_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // Main sequence
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, every breakpoint, every segment middle
        offer_sample(12'd0, 12'd0);
        offer_sample(12'd4095, 12'd4095);
        offer_sample(12'd4095, 12'd0);
        offer_sample(12'd0, 12'd4095);
        offer_sample(12'd4095, 12'd3600);
        offer_sample(12'd1, 12'd1);
        for (int i = 0; i < 9; i++)
            offer_voltage(BP_UV[i]);
        for (int i = 0; i < 8; i++)
            offer_voltage((BP_UV[i] + BP_UV[i+1]) / 2);

        // Reset window length, with a long receiver hold-off up front
        drain();
        burst_req = 1'b1;
        run_random(120);

        write_window(CNT_W'(1));
        run_random(100);

        // Longest window, no idling on either side
        write_window(AVG_MAX);
        quiet_run = 1'b1;
        run_random(200);
        drain();
        quiet_run = 1'b0;

        // Zero acts as one, above the maximum acts as the maximum
        write_window(CNT_W'(0));
        run_random(80);
        write_window(CNT_W'(127));
        run_random(150);

        // Window length lowered with a window half full
        write_window(CNT_W'(1));
        run_random(1);
        write_window(CNT_W'(20));
        run_random(13);
        write_window(CNT_W'(5));
        run_random(60);

        for (int k = 0; k < 4; k++)
        begin
            write_window(CNT_W'($urandom_range(1, 64)));
            run_random(70);
        end

        drain();
        repeat (150) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
